@@ sv/suv_pkg.sv @@
`timescale 1ns / 1ps
package suv_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int UV_FRAC_BITS = 16;
  localparam int CORDIC_ITERS = 24;
  // Normalized operands are shifted together so that the largest has its leading one at bit NORM_W-1.
  localparam int NORM_W       = 30;
  // First-quadrant angle, 0 .. 2^30 in units of 2^-32 turn.
  localparam int ANG_W        = 31;
  // Integer square root of the sum of two squared normalized operands.
  localparam int ROOT_W       = 31;

  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } suv_in_t;

  typedef struct packed {
    logic signed [UV_FRAC_BITS:0] tex_u;
    logic        [UV_FRAC_BITS:0] tex_v;
    logic                         degenerate;
  } suv_out_t;

  // Per-item status carried down the pipeline.
  typedef struct packed {
    logic deg;     // vertex at the origin
    logic sx;      // x negative
    logic sy;      // y negative
    logic sz;      // z negative
    logic zx;      // x is zero
    logic zz;      // z is zero
  } suv_flags_t;

endpackage

@@ sv/suv_norm.sv @@
`timescale 1ns / 1ps
module suv_norm
  import suv_pkg::*;
#(
  parameter int IN_W = 32,
  parameter int N    = 2,
  parameter int SB_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [N-1:0][IN_W-1:0]      in_val,
  input  logic [SB_W-1:0]             in_sb,
  output logic                        out_valid,
  output logic [N-1:0][NORM_W-1:0]    out_val,
  output logic [SB_W-1:0]             out_sb
);

  localparam int PW = $clog2(IN_W);
  localparam logic [PW-1:0] TOP_POS = PW'(NORM_W - 1);

  logic [IN_W-1:0]            orv;
  logic [PW-1:0]              msb;
  logic                       v1_r;
  logic [N-1:0][IN_W-1:0]     val_r;
  logic [PW-1:0]              msb_r;
  logic [SB_W-1:0]            sb1_r;
  logic [N-1:0][NORM_W-1:0]   sh_nxt;
  logic                       v2_r;
  logic [N-1:0][NORM_W-1:0]   out_r;
  logic [SB_W-1:0]            sb2_r;

  // The common shift depends only on the leading one of the OR of all inputs.
  always_comb begin
    orv = '0;
    msb = '0;
    for (int n = 0; n < N; n++) begin
      orv = orv | in_val[n];
    end
    for (int i = 0; i < IN_W; i++) begin
      if (orv[i]) begin
        msb = PW'(i);
      end
    end
  end

  always_comb begin
    logic [IN_W+NORM_W-1:0] wide;
    for (int n = 0; n < N; n++) begin
      wide = {{NORM_W{1'b0}}, val_r[n]};
      if (msb_r >= TOP_POS) begin
        wide = wide >> (msb_r - TOP_POS);
      end else begin
        wide = wide << (TOP_POS - msb_r);
      end
      sh_nxt[n] = wide[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    val_r <= in_val;
    msb_r <= msb;
    sb1_r <= in_sb;
    out_r <= sh_nxt;
    sb2_r <= sb1_r;
  end

  assign out_valid = v2_r;
  assign out_val   = out_r;
  assign out_sb    = sb2_r;

endmodule

@@ sv/suv_sqrt.sv @@
`timescale 1ns / 1ps
module suv_sqrt
  import suv_pkg::*;
#(
  parameter int SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [NORM_W-1:0]    in_a,
  input  logic [NORM_W-1:0]    in_b,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [ROOT_W-1:0]    out_root,
  output logic [SB_W-1:0]      out_sb
);

  localparam int SQ_W  = 2 * NORM_W;
  localparam int SUM_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int DIG   = ROOT_W;

  logic                v1_r, v2_r;
  logic [SQ_W-1:0]     sqa_r, sqb_r;
  logic [SB_W-1:0]     sb1_r, sb2_r;
  logic [SUM_W-1:0]    sum_r;
  logic                vd_r   [DIG+1];
  logic [SUM_W-1:0]    n_r    [DIG+1];
  logic [ROOT_W-1:0]   root_r [DIG+1];
  logic [REM_W-1:0]    rem_r  [DIG+1];
  logic [SB_W-1:0]     sbd_r  [DIG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k <= DIG; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      vd_r[0]  <= v2_r;
      for (int k = 0; k < DIG; k++) begin
        vd_r[k+1] <= vd_r[k];
      end
    end
    sqa_r <= in_a * in_a;
    sqb_r <= in_b * in_b;
    sb1_r <= in_sb;
    sum_r <= SUM_W'(sqa_r) + SUM_W'(sqb_r);
    sb2_r <= sb1_r;
    n_r[0]    <= sum_r;
    root_r[0] <= '0;
    rem_r[0]  <= '0;
    sbd_r[0]  <= sb2_r;
    // One root bit per stage, two radicand bits consumed per stage.
    for (int k = 0; k < DIG; k++) begin
      logic [REM_W+1:0] rem_t;
      logic [REM_W+1:0] trial;
      rem_t = {rem_r[k], n_r[k][SUM_W-1-2*k -: 2]};
      trial = {2'b00, root_r[k], 2'b01};
      if (rem_t >= trial) begin
        rem_r[k+1]  <= REM_W'(rem_t - trial);
        root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k+1]  <= REM_W'(rem_t);
        root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b0};
      end
      n_r[k+1]   <= n_r[k];
      sbd_r[k+1] <= sbd_r[k];
    end
  end

  assign out_valid = vd_r[DIG];
  assign out_root  = root_r[DIG];
  assign out_sb    = sbd_r[DIG];

endmodule

@@ sv/suv_cordic.sv @@
`timescale 1ns / 1ps
module suv_cordic
  import suv_pkg::*;
#(
  parameter int SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [NORM_W-1:0]    in_a,
  input  logic [NORM_W-1:0]    in_b,
  input  logic                 in_za,
  input  logic                 in_zb,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [ANG_W-1:0]     out_ang,
  output logic [SB_W-1:0]      out_sb
);

  localparam int DW = 33;
  localparam logic signed [DW-1:0] QUARTER = DW'(64'sd1 << 30);

  logic                 v_r   [CORDIC_ITERS+1];
  logic signed [DW-1:0] cx_r  [CORDIC_ITERS+1];
  logic signed [DW-1:0] cy_r  [CORDIC_ITERS+1];
  logic signed [DW-1:0] ang_r [CORDIC_ITERS+1];
  logic                 za_r  [CORDIC_ITERS+1];
  logic                 zb_r  [CORDIC_ITERS+1];
  logic [SB_W-1:0]      sb_r  [CORDIC_ITERS+1];
  logic                 vo_r;
  logic [ANG_W-1:0]     ang_o_r;
  logic [ANG_W-1:0]     ang_nxt;
  logic [SB_W-1:0]      sbo_r;

  localparam int LAST = CORDIC_ITERS;

  // A zero b gives angle zero, a zero a gives a quarter turn; otherwise
  // the accumulated angle is clamped into the first quadrant.
  always_comb begin
    if (zb_r[LAST]) begin
      ang_nxt = '0;
    end else if (za_r[LAST] || ang_r[LAST] > QUARTER) begin
      ang_nxt = ANG_W'(QUARTER);
    end else if (ang_r[LAST] < 0) begin
      ang_nxt = '0;
    end else begin
      ang_nxt = ang_r[LAST][ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_ITERS; i++) begin
        v_r[i] <= 1'b0;
      end
      vo_r <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        v_r[i+1] <= v_r[i];
      end
      vo_r <= v_r[LAST];
    end
    cx_r[0]  <= signed'(DW'(in_a));
    cy_r[0]  <= signed'(DW'(in_b));
    ang_r[0] <= '0;
    za_r[0]  <= in_za;
    zb_r[0]  <= in_zb;
    sb_r[0]  <= in_sb;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (!cy_r[i][DW-1]) begin
        cx_r[i+1]  <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1]  <= cy_r[i] - (cx_r[i] >>> i);
        ang_r[i+1] <= ang_r[i] + signed'({1'b0, ATAN_TAB[i]});
      end else begin
        cx_r[i+1]  <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1]  <= cy_r[i] + (cx_r[i] >>> i);
        ang_r[i+1] <= ang_r[i] - signed'({1'b0, ATAN_TAB[i]});
      end
      za_r[i+1] <= za_r[i];
      zb_r[i+1] <= zb_r[i];
      sb_r[i+1] <= sb_r[i];
    end
    ang_o_r <= ang_nxt;
    sbo_r   <= sb_r[LAST];
  end

  assign out_valid = vo_r;
  assign out_ang   = ang_o_r;
  assign out_sb    = sbo_r;

endmodule

@@ sv/spherical_uv_mapping_core.sv @@
`timescale 1ns / 1ps
// Spherical texture coordinates for a stream of vertices. Each item is one
// Q16.16 position; the result is the azimuth tex_u (signed fraction of a
// turn) and the polar angle tex_v (fraction of pi), both in units of 2^-16,
// plus a degenerate flag for the origin. The core is a fixed pipeline that
// takes one item in every clock cycle. The result of an item is shown with
// out_strobe for exactly one cycle, and results leave in order; busy is
// always low. The latency is set mostly by the 34-stage square-root unit
// (two stages for the squares and their sum, one load stage and 31 digit
// stages) and the 26-stage CORDIC units, plus three two-stage normalizers
// and the input and output registers. The receiver must take every result
// as it appears, since nothing in the core can hold a result back.
module spherical_uv_mapping_core
  import suv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  suv_in_t   in_data,
  output logic      out_strobe,
  output suv_out_t  out_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int F     = UV_FRAC_BITS;
  localparam int FL_W  = $bits(suv_flags_t);
  localparam int SBA_W = 3 * CW + FL_W;
  localparam int SBS_W = 3 * NORM_W + FL_W;
  localparam int SBQ_W = 2 * NORM_W + FL_W;
  localparam int TW    = 33;

  // Input register: magnitudes, signs and zero tests.
  logic              s0_v_r;
  logic [CW-1:0]     ax_r, ay_r, az_r;
  suv_flags_t        fl0_r;
  logic [CW-1:0]     ax_nxt, ay_nxt, az_nxt;
  suv_flags_t        fl0_nxt;

  assign busy = 1'b0;

  always_comb begin
    ax_nxt = in_data.pos_x[CW-1] ? CW'(~in_data.pos_x + 1'b1) : in_data.pos_x;
    ay_nxt = in_data.pos_y[CW-1] ? CW'(~in_data.pos_y + 1'b1) : in_data.pos_y;
    az_nxt = in_data.pos_z[CW-1] ? CW'(~in_data.pos_z + 1'b1) : in_data.pos_z;
    fl0_nxt.sx  = in_data.pos_x[CW-1];
    fl0_nxt.sy  = in_data.pos_y[CW-1];
    fl0_nxt.sz  = in_data.pos_z[CW-1];
    fl0_nxt.zx  = (in_data.pos_x == '0);
    fl0_nxt.zz  = (in_data.pos_z == '0);
    fl0_nxt.deg = fl0_nxt.zx && fl0_nxt.zz && (in_data.pos_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    az_r  <= az_nxt;
    fl0_r <= fl0_nxt;
  end

  // Azimuth operands (|x|, |z|) are normalized on their own pair.
  logic                         na_v;
  logic [1:0][NORM_W-1:0]       na_val;
  logic [SBA_W-1:0]             na_sb;

  suv_norm #(.IN_W(CW), .N(2), .SB_W(SBA_W)) u_norm_az (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s0_v_r),
    .in_val   ({ax_r, az_r}),
    .in_sb    ({ax_r, ay_r, az_r, fl0_r}),
    .out_valid(na_v),
    .out_val  (na_val),
    .out_sb   (na_sb)
  );

  // Polar operands: all three magnitudes share one normalization.
  logic                         np_v;
  logic [2:0][NORM_W-1:0]       np_val;
  logic [SBQ_W-1:0]             np_sb;
  suv_flags_t                   fl_a;

  assign fl_a = suv_flags_t'(na_sb[FL_W-1:0]);

  suv_norm #(.IN_W(CW), .N(3), .SB_W(SBQ_W)) u_norm_pol (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (na_v),
    .in_val   (na_sb[SBA_W-1:FL_W]),
    .in_sb    ({na_val[1], na_val[0], fl_a}),
    .out_valid(np_v),
    .out_val  (np_val),
    .out_sb   (np_sb)
  );

  // r = floor(sqrt(x'^2 + z'^2)); y' and the azimuth operands ride along.
  logic                 sq_v;
  logic [ROOT_W-1:0]    sq_root;
  logic [SBS_W-1:0]     sq_sb;
  logic [NORM_W-1:0]    py;

  assign py = sq_sb[SBS_W-1 -: NORM_W];

  suv_sqrt #(.SB_W(SBS_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (np_v),
    .in_a     (np_val[2]),
    .in_b     (np_val[0]),
    .in_sb    ({np_val[1], np_sb}),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // Second normalization for the polar pair (|y'|, r). Its zero tests
  // are taken here, after the first shift.
  logic                         nq_v;
  logic [1:0][NORM_W-1:0]       nq_val;
  logic [SBQ_W+1:0]             nq_sb;
  logic                         zpy, zr;

  assign zpy = (py == '0);
  assign zr  = (sq_root == '0);

  suv_norm #(.IN_W(ROOT_W), .N(2), .SB_W(SBQ_W + 2)) u_norm_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_v),
    .in_val   ({ROOT_W'(py), sq_root}),
    .in_sb    ({sq_sb[SBQ_W-1:0], zpy, zr}),
    .out_valid(nq_v),
    .out_val  (nq_val),
    .out_sb   (nq_sb)
  );

  suv_flags_t               fl_q;
  logic [NORM_W-1:0]        qa_x, qa_z;

  assign fl_q = suv_flags_t'(nq_sb[FL_W+1:2]);
  assign qa_x = nq_sb[SBQ_W+1 -: NORM_W];
  assign qa_z = nq_sb[SBQ_W+1-NORM_W -: NORM_W];

  // Two CORDIC units run side by side with equal latency.
  logic                 ca_v, cp_v;
  logic [ANG_W-1:0]     ang_az, ang_pol;
  logic [1:0]           ca_sb;
  logic [1:0]           cp_sb;

  suv_cordic #(.SB_W(2)) u_cordic_az (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (nq_v),
    .in_a     (qa_x),
    .in_b     (qa_z),
    .in_za    (fl_q.zx),
    .in_zb    (fl_q.zz),
    .in_sb    ({fl_q.sx, fl_q.sz}),
    .out_valid(ca_v),
    .out_ang  (ang_az),
    .out_sb   (ca_sb)
  );

  suv_cordic #(.SB_W(2)) u_cordic_pol (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (nq_v),
    .in_a     (nq_val[1]),
    .in_b     (nq_val[0]),
    .in_za    (nq_sb[1]),
    .in_zb    (nq_sb[0]),
    .in_sb    ({fl_q.deg, fl_q.sy}),
    .out_valid(cp_v),
    .out_ang  (ang_pol),
    .out_sb   (cp_sb)
  );

  // Output stage: unfold the quadrant angles and round to the output grid, or flag a degenerate vertex.
  localparam logic signed [TW-1:0] HALF_TURN = TW'(64'sd1 << 31);
  localparam logic signed [TW-1:0] RND_U     = TW'(64'sd1 << (31 - F));
  localparam logic signed [TW-1:0] RND_V     = TW'(64'sd1 << (30 - F));

  logic                 out_strobe_r;
  suv_out_t             out_data_r;
  suv_out_t             out_nxt;

  always_comb begin
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] a;
    t = signed'(TW'(ang_az));
    if (ca_sb[1]) begin
      t = HALF_TURN - t;
    end
    if (ca_sb[0]) begin
      t = -t;
    end
    t = (t + RND_U) >>> (32 - F);
    a = signed'(TW'(ang_pol));
    if (cp_sb[0]) begin
      a = HALF_TURN - a;
    end
    a = (a + RND_V) >>> (31 - F);
    if (cp_sb[1]) begin
      out_nxt.tex_u      = '0;
      out_nxt.tex_v      = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.tex_u      = t[F:0];
      out_nxt.tex_v      = a[F:0];
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ca_v && cp_v;
    end
    out_data_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import suv_pkg::*;

  localparam int LATENCY  = 66;
  localparam int WD_LIMIT = 2000;
  localparam int N_RANDOM = 1150;

  localparam logic [63:0] ONE64 = 64'd1;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  suv_in_t  in_data;
  logic     out_strobe;
  suv_out_t out_data;

  int idle_pct;
  int quiet_cycles;
  bit failed;

  spherical_uv_mapping_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // Floor shift of a signed 64-bit value.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = ONE64 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // First-quadrant angle of (a, b) in 2^-32 turn, by CORDIC vectoring.
  function automatic longint quadrant_angle(longint unsigned a, longint unsigned b);
    longint unsigned mx;
    longint cx, cy, dx, dy, ang;
    if (b == 0) return 0;
    if (a == 0) return longint'(ONE64 << 30);
    mx = (a > b) ? a : b;
    while (mx >= (ONE64 << 30)) begin
      a = a >> 1; b = b >> 1; mx = mx >> 1;
    end
    while (mx < (ONE64 << 29)) begin
      a = a << 1; b = b << 1; mx = mx << 1;
    end
    cx  = longint'(a);
    cy  = longint'(b);
    ang = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = floor_shr(cy, i);
      dy = floor_shr(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += longint'(ATAN_TAB[i]);
      end else begin
        cx -= dx; cy += dy; ang -= longint'(ATAN_TAB[i]);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > longint'(ONE64 << 30)) ang = longint'(ONE64 << 30);
    return ang;
  endfunction

  function automatic suv_out_t map_vertex(suv_in_t p);
    suv_out_t r;
    longint x, y, z, t, a, u, v;
    longint unsigned ax, ay, az, mx, rt;
    x  = longint'(p.pos_x);
    y  = longint'(p.pos_y);
    z  = longint'(p.pos_z);
    ax = (x < 0) ? longint'(-x) : x;
    ay = (y < 0) ? longint'(-y) : y;
    az = (z < 0) ? longint'(-z) : z;
    r  = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    t = quadrant_angle(ax, az);
    if (x < 0) t = longint'(ONE64 << 31) - t;
    if (z < 0) t = -t;
    u = floor_shr(t + longint'(ONE64 << (31 - UV_FRAC_BITS)), 32 - UV_FRAC_BITS);
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;
    while (mx >= (ONE64 << 30)) begin
      ax = ax >> 1; ay = ay >> 1; az = az >> 1; mx = mx >> 1;
    end
    while (mx < (ONE64 << 29)) begin
      ax = ax << 1; ay = ay << 1; az = az << 1; mx = mx << 1;
    end
    rt = int_sqrt(ax * ax + az * az);
    a  = quadrant_angle(ay, rt);
    if (y < 0) a = longint'(ONE64 << 31) - a;
    v = floor_shr(a + longint'(ONE64 << (30 - UV_FRAC_BITS)), 31 - UV_FRAC_BITS);
    r.tex_u = u[UV_FRAC_BITS:0];
    r.tex_v = v[UV_FRAC_BITS:0];
    return r;
  endfunction

  class uv_scoreboard;
    suv_out_t pending_uv[$];
    int       errors;

    function void note_vertex(suv_in_t p);
      pending_uv.push_back(map_vertex(p));
    endfunction

    function void check_uv(suv_out_t got);
      suv_out_t exp_uv;
      if (pending_uv.size() == 0) begin
        $error("unexpected result u=%0h v=%0h deg=%0b",
               got.tex_u, got.tex_v, got.degenerate);
        errors++;
        return;
      end
      exp_uv = pending_uv.pop_front();
      if (got.tex_u !== exp_uv.tex_u) begin
        $error("tex_u expected %0h actual %0h", exp_uv.tex_u, got.tex_u);
        errors++;
      end
      if (got.tex_v !== exp_uv.tex_v) begin
        $error("tex_v expected %0h actual %0h", exp_uv.tex_v, got.tex_v);
        errors++;
      end
      if (got.degenerate !== exp_uv.degenerate) begin
        $error("degenerate expected %0b actual %0b", exp_uv.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  uv_scoreboard uv_sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are sampled at the edge that ends their cycle; the watchdog
  // counts cycles in which neither side accepted anything.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) uv_sb.check_uv(out_data);
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Drives one vertex and holds it until the core takes it. Random idle
  // cycles go in front, so start only drops when a gap is wanted.
  task automatic send_vertex(suv_in_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    uv_sb.note_vertex(p);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (uv_sb.pending_uv.size() != 0) @(posedge clk);
  endtask

  // Mostly full-range Q16.16 coordinates, sometimes zero, shifted down, short or extreme.
  function automatic logic [31:0] rand_coord();
    int unsigned kind;
    logic [31:0] c;
    kind = $urandom_range(9);
    c = $urandom;
    case (kind)
      0: c = 32'h0;
      1: c = c >>> $urandom_range(31);
      2: c = {{16{c[31]}}, c[15:0]};
      3: c = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: ;
    endcase
    return c;
  endfunction

  function automatic suv_in_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    suv_in_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    return p;
  endfunction

  initial begin
    suv_in_t p;
    suv_in_t directed[$];
    int phase_pct[4] = '{0, 59, 0, 14};

    uv_sb        = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: the origin, each axis both ways, the negative x axis,
    // full-scale extremes and the smallest nonzero coordinates.
    directed.push_back(mk(0, 0, 0));
    directed.push_back(mk(32'h10000, 0, 0));
    directed.push_back(mk(32'hFFFF0000, 0, 0));
    directed.push_back(mk(0, 32'h10000, 0));
    directed.push_back(mk(0, 32'hFFFF0000, 0));
    directed.push_back(mk(0, 0, 32'h10000));
    directed.push_back(mk(0, 0, 32'hFFFF0000));
    directed.push_back(mk(32'h80000000, 0, 0));
    directed.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000));
    directed.push_back(mk(32'h80000000, 0, 32'h7FFFFFFF));
    directed.push_back(mk(1, 0, 0));
    directed.push_back(mk(0, 1, 0));
    directed.push_back(mk(0, 0, 32'hFFFFFFFF));
    directed.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 1));
    directed.push_back(mk(32'hFFFF0000, 0, 32'hFFFFFFFF));
    directed.push_back(mk(32'hFFFF0000, 0, 1));
    directed.push_back(mk(32'h10000, 32'h10000, 32'h10000));
    directed.push_back(mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
    directed.push_back(mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    foreach (directed[i]) send_vertex(directed[i]);

    // The sender holds off here until the pipeline has emptied.
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      idle_pct = phase_pct[(n * 4) / N_RANDOM];
      p = mk(rand_coord(), rand_coord(), rand_coord());
      send_vertex(p);
    end

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    failed = (uv_sb.errors != 0) || (uv_sb.pending_uv.size() != 0);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/suv_pkg.sv
sv/suv_norm.sv
sv/suv_sqrt.sv
sv/suv_cordic.sv
sv/spherical_uv_mapping_core.sv
sim/tb.sv
